@@ rtl/fqbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqbp_pkg
// shared types and constants of the fixed-point quantize bit packer
// ----------------------------------------------------------------------------
package fqbp_pkg;

    // packed output word and input sample layout
    localparam int WORD_BITS    = 16;
    localparam int IN_FRAC_BITS = 16;
    localparam int SAMPLE_W     = 32;
    localparam int INT_PART_W   = SAMPLE_W - IN_FRAC_BITS;

    // bit counts 0..WORD_BITS, and fill level 0..WORD_BITS-1
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int FILL_W = $clog2(WORD_BITS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_BITS = 2'd1;

    // legal code widths; anything else falls back to the minimum
    localparam logic [CFG_DATA_W-1:0] TB_MIN = 5'd5;
    localparam logic [CFG_DATA_W-1:0] TB_MAX = 5'(WORD_BITS);

    localparam logic [CFG_DATA_W-1:0] TB_RESET = TB_MIN;
    localparam logic [CFG_DATA_W-1:0] IB_RESET = 5'd0;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 final_word;
    } t_result;

endpackage

@@ rtl/fixed_point_quantize_bit_packer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_quantize_bit_packer_core
// truncates unsigned 16.16 samples to total_bits codes and packs them msb
// first into 16-bit words, flushing a padded final word on the last sample
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                  payload
// -------   ---  -------------------------  ----------------------------------
// s stream  in   i_s_tvalid / o_s_tready    tdata: sample_value, tlast: last_sample
// m stream  out  o_m_tvalid / i_m_tready    tdata: packed_word, tlast: final_word
// cfg       in   i_cfg_valid / o_cfg_ready  index + 5-bit data (total/integer bits)
//
// one sample is taken per cycle while o_s_tready is high; its code is formed and
// packed in the cycle of the transfer and its zero, one or two words land in a
// 4-entry result queue; the queue drains one word per cycle while i_m_tready is
// high, so input rate is bounded by the word rate at the output
// o_s_tready is high while the queue has room for two words
// i_rst_n is synchronous, active low; it empties the queue, clears the
// partial word and loads total_bits = 5, integer_bits = 0
// config writes are always accepted and take effect on the next sample
//
module fixed_point_quantize_bit_packer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fqbp_pkg::SAMPLE_W-1:0]      i_s_tdata,   // [31:0] sample_value
    input  logic                               i_s_tlast,   // last_sample
    // packed word stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fqbp_pkg::WORD_BITS-1:0]     o_m_tdata,   // [15:0] packed_word
    output logic                               o_m_tlast,   // final_word
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fqbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fqbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int WB     = fqbp_pkg::WORD_BITS;
    localparam int CNT_W  = fqbp_pkg::CNT_W;
    localparam int FILL_W = fqbp_pkg::FILL_W;
    localparam int DW     = fqbp_pkg::CFG_DATA_W;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WB);
    localparam logic [WB-1:0]    ONES     = {WB{1'b1}};

    // configuration registers (raw values, sanitized below)
    logic [DW-1:0] r_total_bits;
    logic [DW-1:0] r_integer_bits;

    // packing state
    logic [WB-1:0]     r_acc;
    logic [FILL_W-1:0] r_bits_filled;
    logic [WB-1:0]     n_acc;
    logic [FILL_W-1:0] n_bits_filled;

    // result queue
    fqbp_pkg::t_result    r_queue [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    logic s_xfer;
    logic m_xfer;

    // quantizer and packer signals
    logic [CNT_W-1:0]                  tb_eff;
    logic [CNT_W-1:0]                  ib_eff;
    logic [CNT_W-1:0]                  frac_bits;
    logic [fqbp_pkg::INT_PART_W-1:0]   int_part;
    logic [fqbp_pkg::IN_FRAC_BITS-1:0] frac_part;
    logic [WB-1:0]                     int_shift;
    logic [WB-1:0]                     frac_shift;
    logic [WB-1:0]                     code;
    logic [CNT_W-1:0]                  fill_sum;
    logic [CNT_W-1:0]                  space;
    logic [CNT_W-1:0]                  rest;
    logic                              split;
    logic                              full;
    logic [WB-1:0]                     acc_a;
    logic [CNT_W-1:0]                  filled_a;
    logic [WB-1:0]                     acc_b;
    logic [CNT_W-1:0]                  filled_b;
    logic [WB-1:0]                     first_word;
    logic [WB-1:0]                     flush_word;
    fqbp_pkg::t_result                 res0;
    fqbp_pkg::t_result                 res1;
    logic [1:0]                        push_cnt;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign s_xfer      = i_s_tvalid & o_s_tready;
    assign o_m_tvalid  = (r_count != '0);
    assign m_xfer      = o_m_tvalid & i_m_tready;
    assign o_m_tdata   = r_queue[r_rd_ptr].word;
    assign o_m_tlast   = r_queue[r_rd_ptr].final_word;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bits   <= fqbp_pkg::TB_RESET;
            r_integer_bits <= fqbp_pkg::IB_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fqbp_pkg::CFG_TOTAL_BITS:   r_total_bits   <= i_cfg_data;
                fqbp_pkg::CFG_INTEGER_BITS: r_integer_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // quantize and pack one sample
    // ------------------------------------------------------------------
    always_comb begin
        // out-of-range code width falls back to the minimum
        if (r_total_bits < fqbp_pkg::TB_MIN || r_total_bits > fqbp_pkg::TB_MAX) begin
            tb_eff = CNT_W'(fqbp_pkg::TB_MIN);
        end else begin
            tb_eff = CNT_W'(r_total_bits);
        end
        // integer bits never exceed the code width
        ib_eff    = (CNT_W'(r_integer_bits) > tb_eff) ? tb_eff : CNT_W'(r_integer_bits);
        frac_bits = tb_eff - ib_eff;

        int_part  = i_s_tdata[fqbp_pkg::SAMPLE_W-1:fqbp_pkg::IN_FRAC_BITS];
        frac_part = i_s_tdata[fqbp_pkg::IN_FRAC_BITS-1:0];

        // zero fraction bits shifts the fraction out entirely
        int_shift  = WB'(int_part) << frac_bits;
        frac_shift = WB'(frac_part >> (CNT_W'(fqbp_pkg::IN_FRAC_BITS) - frac_bits));
        code       = (int_shift | frac_shift) & (ONES >> (WORD_CNT - tb_eff));

        fill_sum = CNT_W'(r_bits_filled) + tb_eff;
        split    = (fill_sum > WORD_CNT);
        space    = WORD_CNT - CNT_W'(r_bits_filled);
        rest     = fill_sum - WORD_CNT;

        if (split) begin
            // code straddles the word boundary
            first_word = (r_acc << space) | (code >> rest);
            acc_a      = code & (ONES >> (WORD_CNT - rest));
            filled_a   = rest;
        end else begin
            first_word = (r_acc << tb_eff) | code;
            acc_a      = first_word;
            filled_a   = fill_sum;
        end

        // word filled exactly
        full = (filled_a == WORD_CNT);
        if (full) begin
            acc_b    = '0;
            filled_b = '0;
        end else begin
            acc_b    = acc_a;
            filled_b = filled_a;
        end

        // left-aligned padded flush word, zero when nothing remains
        flush_word = acc_b << (WORD_CNT - filled_b);

        res1.word       = flush_word;
        res1.final_word = 1'b1;
        if (split || full) begin
            res0.word       = first_word;
            res0.final_word = 1'b0;
        end else begin
            res0 = res1;
        end
        push_cnt = 2'({1'b0, split | full}) + 2'({1'b0, i_s_tlast});

        if (i_s_tlast) begin
            n_acc         = '0;
            n_bits_filled = '0;
        end else begin
            n_acc         = acc_b;
            n_bits_filled = FILL_W'(filled_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_bits_filled <= '0;
        end else if (s_xfer) begin
            r_acc         <= n_acc;
            r_bits_filled <= n_bits_filled;
        end
    end

    // ------------------------------------------------------------------
    // result queue: up to two pushes and one pop per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_xfer && push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (s_xfer && push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + Q_PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (s_xfer) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(push_cnt);
            end
            if (m_xfer) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + (s_xfer ? Q_CNT_W'(push_cnt) : '0)
                       - Q_CNT_W'(m_xfer);
        end
    end

endmodule

@@ rtl/fqbp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqbp_checker
// port-level checks of the bit packer core, bound to the top level
// ----------------------------------------------------------------------------
module fqbp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               i_s_tlast,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [fqbp_pkg::WORD_BITS-1:0]     o_m_tdata,
    input logic                               o_m_tlast
);

    // stalled word stays offered
    a_m_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    // stalled word keeps its payload
    a_m_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // a last sample always produces at least the final word
    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("no word after last sample");

    // an empty output side always takes a sample
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind fixed_point_quantize_bit_packer_core fqbp_checker u_fqbp_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed-point quantize bit packer: a cycle-free
// packing model predicts every output word, random stalls on both streams,
// directed corner cases, random streams under many code widths, and a long
// output hold-off that backs the block up
// ----------------------------------------------------------------------------
module tb_top;

    // unused register indexes, writes there must be ignored
    localparam logic [fqbp_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [fqbp_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // cycles to let the block settle after the last expected word
    localparam int DRAIN_CYCLES = 8;
    // generous bound on the whole run
    localparam int CYCLE_LIMIT  = 400000;

    // dut inputs, all known from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic [fqbp_pkg::SAMPLE_W-1:0]   i_s_tdata   = '0;
    logic                            i_s_tlast   = 1'b0;
    logic                            i_m_tready  = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [fqbp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [fqbp_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // dut outputs
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [fqbp_pkg::WORD_BITS-1:0]  o_m_tdata;
    logic                            o_m_tlast;
    logic                            o_cfg_ready;

    // packing model state, mirrors the block after reset
    logic [fqbp_pkg::CFG_DATA_W-1:0] cfg_total   = fqbp_pkg::TB_RESET;
    logic [fqbp_pkg::CFG_DATA_W-1:0] cfg_integer = fqbp_pkg::IB_RESET;
    logic [fqbp_pkg::WORD_BITS-1:0]  pk_acc      = '0;
    logic [4:0]                      pk_fill     = '0;

    // words predicted but not yet seen at the output
    fqbp_pkg::t_result words_due[$];
    fqbp_pkg::t_result due_word;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // idling controls shared with the stimulus tasks
    bit          tx_steady       = 1'b0;
    bit          rx_steady       = 1'b0;
    int unsigned rx_hold_cycles  = 0;
    int unsigned rx_stall_left   = 0;

    fixed_point_quantize_bit_packer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [31:0] sample_value
        .i_s_tlast   (i_s_tlast),    // last_sample
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [15:0] packed_word
        .o_m_tlast   (o_m_tlast),    // final_word
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // quantize one sample with the current widths and pack it msb first,
    // queueing every word it completes plus the flushed word on the last one
    function automatic void pack_sample(input logic [31:0] value, input logic last);
        int unsigned tb;
        int unsigned ib;
        int unsigned fb;
        int unsigned fill;
        int unsigned space;
        int unsigned rest;
        logic [63:0] fcode;
        logic [63:0] code;
        logic [31:0] acc;
        // out-of-range widths fall back to the minimum, integer bits clamp
        tb = cfg_total;
        if (tb < fqbp_pkg::TB_MIN || tb > fqbp_pkg::TB_MAX) begin
            tb = fqbp_pkg::TB_MIN;
        end
        ib = (cfg_integer > tb) ? tb : cfg_integer;
        fb = tb - ib;
        // top fb bits of the fraction, integer part above them, masked to tb
        fcode = (fb == 0) ? 64'd0
                          : (64'(value[15:0]) >> (fqbp_pkg::IN_FRAC_BITS - fb));
        code  = ((64'(value[31:16]) << fb) | fcode) & ((64'd1 << tb) - 64'd1);
        fill  = pk_fill;
        acc   = 32'(pk_acc);
        if (tb + fill <= fqbp_pkg::WORD_BITS) begin
            acc  = ((acc << tb) | code[31:0]) & 32'hFFFF;
            fill = fill + tb;
        end else begin
            // code straddles the word boundary: head closes this word
            space = fqbp_pkg::WORD_BITS - fill;
            rest  = tb - space;
            words_due.push_back({16'((acc << space) | (code[31:0] >> rest)), 1'b0});
            acc  = code[31:0] & ((32'd1 << rest) - 32'd1);
            fill = rest;
        end
        if (fill == fqbp_pkg::WORD_BITS) begin
            words_due.push_back({acc[15:0], 1'b0});
            acc  = '0;
            fill = 0;
        end
        if (last) begin
            // left-aligned, zero-padded, sent even when empty
            words_due.push_back({16'(acc << (fqbp_pkg::WORD_BITS - fill)), 1'b1});
            acc  = '0;
            fill = 0;
        end
        pk_acc  = acc[15:0];
        pk_fill = fill[4:0];
    endfunction

    // idle length: mostly none, often short, now and then long
    function automatic int unsigned idle_length(input bit steady);
        int unsigned r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d: %s expected %h actual %h",
                     cycle_count, what, want, got);
        end
    endtask

    // result checker: each word transfer is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (words_due.size() == 0) begin
                report_mismatch("word with none predicted", 16'h0000, o_m_tdata);
            end else begin
                due_word = words_due.pop_front();
                if (o_m_tdata !== due_word.word) begin
                    report_mismatch("packed_word", due_word.word, o_m_tdata);
                end
                if (o_m_tlast !== due_word.final_word) begin
                    report_mismatch("final_word", 16'(due_word.final_word), 16'(o_m_tlast));
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_cycles != 0) begin
            i_m_tready <= 1'b0;
            rx_hold_cycles--;
        end else if (rx_stall_left != 0) begin
            i_m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            rx_stall_left = idle_length(rx_steady);
            if (rx_stall_left != 0) begin
                i_m_tready <= 1'b0;
                rx_stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one sample after a random gap; tvalid is left high after the
    // transfer so back-to-back samples need no drop, tx_idle lowers it
    task automatic send_sample(input logic [31:0] value, input logic last);
        int unsigned gap;
        gap = idle_length(tx_steady);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pack_sample(value, last);
    endtask

    task automatic tx_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every predicted word, then let the block settle
    task automatic wait_drain();
        tx_idle();
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fqbp_pkg::CFG_IDX_W-1:0] index,
                             input logic [fqbp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == fqbp_pkg::CFG_TOTAL_BITS) begin
            cfg_total = data;
        end else if (index == fqbp_pkg::CFG_INTEGER_BITS) begin
            cfg_integer = data;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic set_widths(input logic [fqbp_pkg::CFG_DATA_W-1:0] total,
                              input logic [fqbp_pkg::CFG_DATA_W-1:0] integ);
        wait_drain();
        write_reg(fqbp_pkg::CFG_TOTAL_BITS, total);
        write_reg(fqbp_pkg::CFG_INTEGER_BITS, integ);
    endtask

    // corner cases, about twenty samples
    task automatic test_directed();
        // reset widths 5.0: extremes, then a straddling word and a flush
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h1234_8000, 1'b0);
        send_sample(32'hABCD_F0F0, 1'b1);
        // all integer, no fraction bits; exact fill then an empty flush word
        set_widths(5'd16, 5'd16);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'h0001_FFFF, 1'b1);
        // all fraction bits
        set_widths(5'd16, 5'd0);
        send_sample(32'h0000_FFFF, 1'b0);
        send_sample(32'h5A5A_8001, 1'b1);
        // width out of range falls back to five, integer bits clamp to it
        set_widths(5'd31, 5'd31);
        send_sample(32'h001F_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        set_widths(5'd4, 5'd2);
        send_sample(32'h0003_E000, 1'b1);
        set_widths(5'd17, 5'd0);
        send_sample(32'h8000_8000, 1'b1);
        set_widths(5'd0, 5'd0);
        send_sample(32'h0001_0000, 1'b1);
        // integer bits above the code width
        set_widths(5'd6, 5'd10);
        send_sample(32'hFFC0_1234, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        // spare indexes change nothing
        wait_drain();
        write_reg(CFG_SPARE_2, 5'd9);
        write_reg(CFG_SPARE_3, 5'd1);
        // integer overflow is masked away
        set_widths(5'd8, 5'd3);
        send_sample(32'h00FF_FFFF, 1'b0);
        send_sample(32'h0005_2000, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
        // wide codes straddle nearly every word
        set_widths(5'd15, 5'd1);
        send_sample(32'h0001_7FFF, 1'b0);
        send_sample(32'h0000_AAAA, 1'b1);
    endtask

    // random streams under many width settings, some left open across changes
    task automatic test_random_streams();
        logic [fqbp_pkg::CFG_DATA_W-1:0] total;
        logic [fqbp_pkg::CFG_DATA_W-1:0] integ;
        logic [31:0]                     value;
        int unsigned                     left;
        int unsigned                     run;
        int unsigned                     r;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin
                    total = 5'd16;
                    integ = 5'd0;
                end
                1: begin
                    total = 5'd5;
                    integ = 5'd5;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        total = 5'd5;
                    end else if (r == 1) begin
                        total = 5'd16;
                    end else if (r == 2) begin
                        total = 5'($urandom_range(0, 31));
                    end else begin
                        total = 5'($urandom_range(5, 16));
                    end
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        integ = 5'd0;
                    end else if (r == 1) begin
                        integ = total;
                    end else if (r == 2) begin
                        integ = 5'($urandom_range(0, 31));
                    end else begin
                        integ = 5'($urandom_range(0, total));
                    end
                end
            endcase
            set_widths(total, integ);
            // some stretches with no idling on one or both sides
            tx_steady = (phase % 4 == 1);
            rx_steady = (phase % 4 == 1) || (phase % 4 == 2);
            left = 50;
            while (left != 0) begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 10);
                if (run > left) begin
                    run = left;
                end
                for (int k = 0; k < run; k++) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        value = 32'hFFFF_FFFF;
                    end else if (r == 1) begin
                        value = 32'h0000_0000;
                    end else if (r == 2) begin
                        value = {16'($urandom_range(0, 3)), 16'($urandom)};
                    end else begin
                        value = $urandom;
                    end
                    // a phase ending with an open stream carries it into new widths
                    send_sample(value, (k == run - 1) &&
                                       !(run == left && phase % 4 == 3));
                end
                left = left - run;
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
    endtask

    // receiver holds off long while samples keep coming, so the block fills
    // and stalls its input
    task automatic test_output_hold();
        set_widths(5'd16, 5'd8);
        rx_hold_cycles = 300;
        tx_steady = 1'b1;
        for (int k = 0; k < 40; k++) begin
            send_sample($urandom, k == 39);
        end
        tx_steady = 1'b0;
        wait_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_streams();
        test_output_hold();
        wait_drain();
        // predictions never matched by a word
        if (words_due.size() != 0) begin
            mismatch_count += words_due.size();
            $display("%0d predicted words never arrived", words_due.size());
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
